// ===== src/cstsum_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cstsum_pkg: shared types and constants for the subarray target-sum counter
// Default sizes, fixed field widths and the control word that walks the chain.
// ----------------------------------------------------------------------------
package cstsum_pkg;

  localparam int DEPTH_DEFAULT       = 1024;
  localparam int VALUE_BITS_DEFAULT  = 16;

  // Widths that follow from the default sizes, used as module defaults below the top.
  localparam int PREFIX_BITS_DEFAULT = VALUE_BITS_DEFAULT + $clog2(DEPTH_DEFAULT) + 1;
  localparam int TARGET_BITS         = 32;
  localparam int WANT_BITS_DEFAULT   =
    ((PREFIX_BITS_DEFAULT > TARGET_BITS) ? PREFIX_BITS_DEFAULT : TARGET_BITS) + 1;
  localparam int FILL_BITS_DEFAULT   = $clog2(DEPTH_DEFAULT + 1);
  localparam int HIT_BITS_DEFAULT    = $clog2(DEPTH_DEFAULT + 1);

  localparam int COUNT_BITS    = 20;
  localparam int OUT_DATA_BITS = ((COUNT_BITS + 7) / 8) * 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Control word of one query as it moves from cell to cell.
  typedef struct packed {
    logic valid;    // a query occupies this stage
    logic last;     // final element of the array
    logic dropped;  // element arrived with the store full; it only carries its mark
  } ctrl_t;

endpackage
`default_nettype wire

// ===== src/cstsum_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cstsum_cell: one cell of the prefix chain
// Holds one stored prefix, scores a passing query against it and hands the
// query on to the next cell.
// ----------------------------------------------------------------------------
module cstsum_cell #(
  parameter int CELL_INDEX  = 0,
  parameter int PREFIX_BITS = cstsum_pkg::PREFIX_BITS_DEFAULT,
  parameter int WANT_BITS   = cstsum_pkg::WANT_BITS_DEFAULT,
  parameter int FILL_BITS   = cstsum_pkg::FILL_BITS_DEFAULT,
  parameter int HIT_BITS    = cstsum_pkg::HIT_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  cstsum_pkg::ctrl_t             in_ctrl,
  input  logic signed [PREFIX_BITS-1:0] in_prefix,
  input  logic signed [WANT_BITS-1:0]   in_want,
  input  logic        [FILL_BITS-1:0]   in_idx,
  input  logic        [HIT_BITS-1:0]    in_hits,
  output cstsum_pkg::ctrl_t             out_ctrl,
  output logic signed [PREFIX_BITS-1:0] out_prefix,
  output logic signed [WANT_BITS-1:0]   out_want,
  output logic        [FILL_BITS-1:0]   out_idx,
  output logic        [HIT_BITS-1:0]    out_hits
);

  logic signed [PREFIX_BITS-1:0] stored;
  logic                          live;
  logic                          hit;
  logic                          write_here;

  assign live       = in_ctrl.valid && !in_ctrl.dropped;
  // Only prefixes stored earlier in this array (lower index) are compared.
  assign hit        = live && (in_idx > FILL_BITS'(CELL_INDEX)) &&
                      (WANT_BITS'(stored) == in_want);
  assign write_here = live && (in_idx == FILL_BITS'(CELL_INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else if (advance) begin
      out_ctrl <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_prefix <= in_prefix;
      out_want   <= in_want;
      out_idx    <= in_idx;
      out_hits   <= in_hits + HIT_BITS'(hit);
      if (write_here) begin
        stored <= in_prefix;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/count_subarrays_with_target_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// count_subarrays_with_target_sum: streaming subarray target-sum counter
// Counts contiguous subarrays of a framed element stream whose sum equals a
// programmable target, using a systolic chain of prefix-holding cells.
// ----------------------------------------------------------------------------
// Each input word carries one signed element (low VALUE_BITS of tdata) and
// tlast on the final element of an array. The block accepts one element per
// clock. An accepted element is turned into a query (new running prefix P and
// the wanted earlier prefix P - target) that walks a chain of DEPTH cells, one
// cell per cycle; cell j holds prefix j of the current array and scores every
// later query of the same array. The result word (match count, overflow flag
// in tuser) is registered once the last element has passed the head stage and
// every cell of the chain. Whenever the output register holds a result that is
// not taken, the whole chain freezes and tready drops. Elements beyond DEPTH
// in one array are ignored apart from their tlast, and the overflow flag is
// set in that array's result. Write target_sum only while no element is in
// flight.
// ----------------------------------------------------------------------------
module count_subarrays_with_target_sum #(
  parameter int DEPTH      = cstsum_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = cstsum_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // target_sum register
  input  logic                                    cfg_we,
  input  logic [cstsum_pkg::TARGET_BITS-1:0]      cfg_wdata,
  // element stream
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]         s_axis_tdata,  // [VALUE_BITS-1:0] element_value
  input  logic                                    s_axis_tlast,  // last_element
  // result stream
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [cstsum_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,  // [19:0] match_count
  output logic                                    m_axis_tuser   // overflow
);

  localparam int PREFIX_BITS = VALUE_BITS + $clog2(DEPTH) + 1;
  localparam int WANT_BITS   = ((PREFIX_BITS > cstsum_pkg::TARGET_BITS) ?
                                PREFIX_BITS : cstsum_pkg::TARGET_BITS) + 1;
  localparam int FILL_BITS   = $clog2(DEPTH + 1);
  localparam int HIT_BITS    = $clog2(DEPTH + 1);
  localparam int COUNT_BITS  = cstsum_pkg::COUNT_BITS;

  // --------------------------------------------------------------------------
  // Flow control: the chain moves whenever the output register can take a word
  // --------------------------------------------------------------------------
  logic advance;
  logic in_accept;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Head: target register, running prefix and fill level of the current array
  // --------------------------------------------------------------------------
  logic signed [cstsum_pkg::TARGET_BITS-1:0] target_sum;
  logic signed [PREFIX_BITS-1:0]             running_prefix;
  logic        [FILL_BITS-1:0]               fill_level;

  logic signed [PREFIX_BITS-1:0] elem_ext;
  logic signed [PREFIX_BITS-1:0] prefix_next;
  logic signed [WANT_BITS-1:0]   want_next;
  logic                          room;

  assign elem_ext    = PREFIX_BITS'($signed(s_axis_tdata[VALUE_BITS-1:0]));
  assign prefix_next = running_prefix + elem_ext;
  assign want_next   = WANT_BITS'(prefix_next) - WANT_BITS'(target_sum);
  assign room        = fill_level < FILL_BITS'(DEPTH);

  cstsum_pkg::ctrl_t             head_ctrl;
  logic signed [PREFIX_BITS-1:0] head_prefix;
  logic signed [WANT_BITS-1:0]   head_want;
  logic        [FILL_BITS-1:0]   head_idx;
  logic        [HIT_BITS-1:0]    head_hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum     <= '0;
      running_prefix <= '0;
      fill_level     <= '0;
      head_ctrl      <= '0;
    end else begin
      if (cfg_we) begin
        target_sum <= cfg_wdata;
      end
      if (advance) begin
        head_ctrl.valid   <= in_accept;
        head_ctrl.last    <= s_axis_tlast;
        head_ctrl.dropped <= !room;
      end
      if (in_accept) begin
        // Close the array on its last element; otherwise grow it while space is left.
        if (s_axis_tlast) begin
          running_prefix <= '0;
          fill_level     <= '0;
        end else if (room) begin
          running_prefix <= prefix_next;
          fill_level     <= fill_level + FILL_BITS'(1);
        end
      end
    end
  end

  // The implicit leading zero prefix scores here: the whole run so far matches.
  // A dropped element scores nothing.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      head_prefix <= prefix_next;
      head_want   <= want_next;
      head_idx    <= fill_level;
      head_hits   <= HIT_BITS'(room && (want_next == '0));
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: link 0 is the head stage, link DEPTH feeds the tail
  // --------------------------------------------------------------------------
  cstsum_pkg::ctrl_t             link_ctrl   [0:DEPTH];
  logic signed [PREFIX_BITS-1:0] link_prefix [0:DEPTH];
  logic signed [WANT_BITS-1:0]   link_want   [0:DEPTH];
  logic        [FILL_BITS-1:0]   link_idx    [0:DEPTH];
  logic        [HIT_BITS-1:0]    link_hits   [0:DEPTH];

  assign link_ctrl[0]   = head_ctrl;
  assign link_prefix[0] = head_prefix;
  assign link_want[0]   = head_want;
  assign link_idx[0]    = head_idx;
  assign link_hits[0]   = head_hits;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cstsum_cell #(
      .CELL_INDEX  (g),
      .PREFIX_BITS (PREFIX_BITS),
      .WANT_BITS   (WANT_BITS),
      .FILL_BITS   (FILL_BITS),
      .HIT_BITS    (HIT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .in_ctrl    (link_ctrl[g]),
      .in_prefix  (link_prefix[g]),
      .in_want    (link_want[g]),
      .in_idx     (link_idx[g]),
      .in_hits    (link_hits[g]),
      .out_ctrl   (link_ctrl[g+1]),
      .out_prefix (link_prefix[g+1]),
      .out_want   (link_want[g+1]),
      .out_idx    (link_idx[g+1]),
      .out_hits   (link_hits[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Tail: accumulate per-element hits, emit the count on the last element
  // --------------------------------------------------------------------------
  cstsum_pkg::ctrl_t     tail_ctrl;
  logic [HIT_BITS-1:0]   tail_hits;
  logic [COUNT_BITS-1:0] count_so_far;
  logic                  overflow_seen;
  logic [COUNT_BITS:0]   count_sum;
  logic [COUNT_BITS-1:0] count_next;
  logic                  overflow_next;
  logic                  tail_take;

  assign tail_ctrl     = link_ctrl[DEPTH];
  assign tail_hits     = link_hits[DEPTH];
  assign tail_take     = advance && tail_ctrl.valid;
  assign count_sum     = (COUNT_BITS+1)'(count_so_far) + (COUNT_BITS+1)'(tail_hits);
  // Saturate at the top of the count field.
  assign count_next    = count_sum[COUNT_BITS] ? cstsum_pkg::COUNT_MAX :
                         count_sum[COUNT_BITS-1:0];
  assign overflow_next = overflow_seen || tail_ctrl.dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_so_far  <= '0;
      overflow_seen <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (tail_take) begin
        if (tail_ctrl.last) begin
          count_so_far  <= '0;
          overflow_seen <= 1'b0;
        end else begin
          count_so_far  <= count_next;
          overflow_seen <= overflow_next;
        end
      end
      if (tail_take && tail_ctrl.last) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_take && tail_ctrl.last) begin
      m_axis_tdata <= cstsum_pkg::OUT_DATA_BITS'(count_next);
      m_axis_tuser <= overflow_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A result word only follows a last element leaving the chain.
  a_result_from_last : assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(advance && tail_ctrl.valid && tail_ctrl.last))
    else $error("result word without a last element at the tail");

  // The fill level never runs past the cell count.
  a_fill_bounded : assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_BITS'(DEPTH))
    else $error("fill level beyond DEPTH");

  // An element taken with the chain full becomes a dropped query.
  a_full_drops : assert property (@(posedge clk) disable iff (rst)
    (in_accept && !room) |=> (head_ctrl.valid && head_ctrl.dropped))
    else $error("element accepted with full chain was not dropped");

  // A query can match at most every earlier prefix plus the leading zero.
  a_hits_bounded : assert property (@(posedge clk) disable iff (rst)
    (tail_ctrl.valid && !tail_ctrl.dropped) |->
      (int'(tail_hits) <= int'(link_idx[DEPTH]) + 1))
    else $error("hit count exceeds number of earlier prefixes");

  // Stalled output freezes the tail of the chain.
  a_stall_holds_tail : assert property (@(posedge clk) disable iff (rst)
    (!advance && !rst) |=> $stable(tail_ctrl))
    else $error("chain moved while output stalled");

endmodule
`default_nettype wire
